FILE: src/lsp_pkg.sv
package lsp_pkg;

  localparam int MAX_STRIPS      = 3;
  localparam int COLOURS         = 3;
  localparam int BITS_PER_COLOUR = 8;
  localparam int SLOT_BITS       = COLOURS * BITS_PER_COLOUR;

  typedef logic [7:0] byte_t;
  typedef logic [1:0] colour_t;
  typedef logic [2:0] order_t;
  typedef logic [2:0] bit_idx_t;
  typedef logic [1:0] reg_idx_t;

  // colour indexes
  localparam colour_t COLOUR_RED   = 2'd0;
  localparam colour_t COLOUR_GREEN = 2'd1;
  localparam colour_t COLOUR_BLUE  = 2'd2;

  // wire order codes
  localparam order_t ORDER_RGB = 3'd0;
  localparam order_t ORDER_RBG = 3'd1;
  localparam order_t ORDER_GRB = 3'd2;
  localparam order_t ORDER_GBR = 3'd3;
  localparam order_t ORDER_BRG = 3'd4;
  localparam order_t ORDER_BGR = 3'd5;

  // configuration register indexes
  localparam reg_idx_t REG_ONE_WIDTH    = 2'd0;
  localparam reg_idx_t REG_ZERO_WIDTH   = 2'd1;
  localparam reg_idx_t REG_COLOUR_ORDER = 2'd2;

  localparam colour_t  LAST_COLOUR = colour_t'(COLOURS - 1);
  localparam bit_idx_t LAST_BIT    = bit_idx_t'(BITS_PER_COLOUR - 1);

  typedef struct packed {
    logic load;
    logic shift;
  } lane_ctrl_t;

  localparam byte_t GAMMA_LUT [256] = '{
    8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0,
    8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0,
    8'd0, 8'd0, 8'd1, 8'd1, 8'd1, 8'd1, 8'd1, 8'd1, 8'd1, 8'd1, 8'd1,
    8'd1, 8'd1, 8'd1, 8'd1, 8'd2, 8'd2, 8'd2, 8'd2, 8'd2, 8'd2, 8'd2, 8'd2,
    8'd3, 8'd3, 8'd3, 8'd3, 8'd3, 8'd3, 8'd3, 8'd4, 8'd4, 8'd4, 8'd4, 8'd4,
    8'd5, 8'd5, 8'd5, 8'd5, 8'd6, 8'd6, 8'd6, 8'd6, 8'd7, 8'd7, 8'd7, 8'd7,
    8'd8, 8'd8, 8'd8, 8'd9, 8'd9, 8'd9, 8'd10, 8'd10, 8'd10, 8'd11,
    8'd11, 8'd11, 8'd12, 8'd12, 8'd13, 8'd13, 8'd13, 8'd14, 8'd14, 8'd15,
    8'd15, 8'd16, 8'd16, 8'd17, 8'd17, 8'd18, 8'd18, 8'd19,
    8'd19, 8'd20, 8'd20, 8'd21, 8'd21, 8'd22, 8'd22, 8'd23, 8'd24, 8'd24,
    8'd25, 8'd25, 8'd26, 8'd27, 8'd27, 8'd28, 8'd29, 8'd29,
    8'd30, 8'd31, 8'd32, 8'd32, 8'd33, 8'd34, 8'd35, 8'd35, 8'd36, 8'd37,
    8'd38, 8'd39, 8'd39, 8'd40, 8'd41, 8'd42, 8'd43, 8'd44,
    8'd45, 8'd46, 8'd47, 8'd48, 8'd49, 8'd50, 8'd50, 8'd51, 8'd52, 8'd54,
    8'd55, 8'd56, 8'd57, 8'd58, 8'd59, 8'd60, 8'd61, 8'd62,
    8'd63, 8'd64, 8'd66, 8'd67, 8'd68, 8'd69, 8'd70, 8'd72, 8'd73, 8'd74,
    8'd75, 8'd77, 8'd78, 8'd79, 8'd81, 8'd82, 8'd83, 8'd85,
    8'd86, 8'd87, 8'd89, 8'd90, 8'd92, 8'd93, 8'd95, 8'd96, 8'd98, 8'd99,
    8'd101, 8'd102, 8'd104, 8'd105, 8'd107, 8'd109,
    8'd110, 8'd112, 8'd114, 8'd115, 8'd117, 8'd119, 8'd120, 8'd122, 8'd124,
    8'd126, 8'd127, 8'd129, 8'd131, 8'd133,
    8'd135, 8'd137, 8'd138, 8'd140, 8'd142, 8'd144, 8'd146, 8'd148, 8'd150,
    8'd152, 8'd154, 8'd156, 8'd158, 8'd160,
    8'd162, 8'd164, 8'd167, 8'd169, 8'd171, 8'd173, 8'd175, 8'd177, 8'd180,
    8'd182, 8'd184, 8'd186, 8'd189, 8'd191,
    8'd193, 8'd196, 8'd198, 8'd200, 8'd203, 8'd205, 8'd208, 8'd210, 8'd213,
    8'd215, 8'd218, 8'd220, 8'd223, 8'd225,
    8'd228, 8'd231, 8'd233, 8'd236, 8'd239, 8'd241, 8'd244, 8'd247, 8'd249,
    8'd252, 8'd255
  };

  // colours in wire order, first colour in the top two bits
  function automatic logic [5:0] colour_seq(order_t order);
    logic [5:0] seq;
    unique case (order)
      ORDER_RGB: seq = {COLOUR_RED,   COLOUR_GREEN, COLOUR_BLUE};
      ORDER_RBG: seq = {COLOUR_RED,   COLOUR_BLUE,  COLOUR_GREEN};
      ORDER_GRB: seq = {COLOUR_GREEN, COLOUR_RED,   COLOUR_BLUE};
      ORDER_GBR: seq = {COLOUR_GREEN, COLOUR_BLUE,  COLOUR_RED};
      ORDER_BRG: seq = {COLOUR_BLUE,  COLOUR_RED,   COLOUR_GREEN};
      ORDER_BGR: seq = {COLOUR_BLUE,  COLOUR_GREEN, COLOUR_RED};
      default:   seq = {COLOUR_RED,   COLOUR_GREEN, COLOUR_BLUE};
    endcase
    return seq;
  endfunction

endpackage

FILE: src/lsp_lane.sv
module lsp_lane (
  input  logic                clk,
  input  lsp_pkg::lane_ctrl_t ctrl,
  input  lsp_pkg::order_t     colour_order,
  input  lsp_pkg::byte_t      red,
  input  lsp_pkg::byte_t      green,
  input  lsp_pkg::byte_t      blue,
  output logic                bit_out
);

  logic [lsp_pkg::SLOT_BITS-1:0] word;
  logic [lsp_pkg::SLOT_BITS-1:0] word_next;
  lsp_pkg::byte_t                corrected [lsp_pkg::COLOURS];
  logic [5:0]                    seq;

  function automatic lsp_pkg::byte_t pick(lsp_pkg::colour_t c, lsp_pkg::byte_t r,
                                          lsp_pkg::byte_t g, lsp_pkg::byte_t b);
    lsp_pkg::byte_t v;
    unique case (c)
      lsp_pkg::COLOUR_RED:   v = r;
      lsp_pkg::COLOUR_GREEN: v = g;
      lsp_pkg::COLOUR_BLUE:  v = b;
      default:               v = r;
    endcase
    return v;
  endfunction

  always_comb begin
    corrected[0] = lsp_pkg::GAMMA_LUT[red];
    corrected[1] = lsp_pkg::GAMMA_LUT[green];
    corrected[2] = lsp_pkg::GAMMA_LUT[blue];
    seq = lsp_pkg::colour_seq(colour_order);
    // first wire colour lands in the top byte so the msb goes out first
    word_next = {pick(seq[5:4], corrected[0], corrected[1], corrected[2]),
                 pick(seq[3:2], corrected[0], corrected[1], corrected[2]),
                 pick(seq[1:0], corrected[0], corrected[1], corrected[2])};
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      word <= word_next;
    end else if (ctrl.shift) begin
      word <= {word[lsp_pkg::SLOT_BITS-2:0], 1'b0};
    end
  end

  assign bit_out = word[lsp_pkg::SLOT_BITS-1];

endmodule

FILE: src/lsp_merge.sv
module lsp_merge #(
  parameter int STRIP_COUNT = 3
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic                                 in_blank,
  input  lsp_pkg::byte_t                       one_width,
  input  lsp_pkg::byte_t                       zero_width,
  input  logic [lsp_pkg::MAX_STRIPS-1:0]       lane_bits,
  output lsp_pkg::lane_ctrl_t                  lane_ctrl,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output lsp_pkg::byte_t                       out_width [lsp_pkg::MAX_STRIPS],
  output lsp_pkg::colour_t                     out_colour,
  output lsp_pkg::bit_idx_t                    out_bit,
  output logic                                 out_last
);

  logic              busy;
  logic              blank;
  lsp_pkg::colour_t  colour;
  lsp_pkg::bit_idx_t bit_pos;
  logic              advance;
  logic              final_slot;
  logic              load;

  assign advance    = busy && (!out_valid || out_ready);
  assign final_slot = (colour == lsp_pkg::LAST_COLOUR) && (bit_pos == lsp_pkg::LAST_BIT);
  // next pixel goes in on the cycle its predecessor's final slot is issued
  assign in_ready   = !busy || (advance && final_slot);
  assign load       = in_valid && in_ready;

  assign lane_ctrl.load  = load;
  assign lane_ctrl.shift = advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      out_valid <= 1'b0;
      colour    <= '0;
      bit_pos   <= '0;
    end else begin
      if (load) begin
        busy  <= 1'b1;
        blank <= in_blank;
      end else if (advance && final_slot) begin
        busy <= 1'b0;
      end

      if (advance) begin
        out_valid  <= 1'b1;
        out_colour <= colour;
        out_bit    <= bit_pos;
        out_last   <= final_slot;
        for (int s = 0; s < lsp_pkg::MAX_STRIPS; s++) begin
          if (blank || s >= STRIP_COUNT) begin
            out_width[s] <= '0;
          end else begin
            out_width[s] <= lane_bits[s] ? one_width : zero_width;
          end
        end
        if (final_slot) begin
          colour  <= '0;
          bit_pos <= '0;
        end else if (bit_pos == lsp_pkg::LAST_BIT) begin
          bit_pos <= '0;
          colour  <= colour + 2'd1;
        end else begin
          bit_pos <= bit_pos + 3'd1;
        end
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

FILE: src/led_strip_pulse_encoder.sv
// Pulse encoder for up to three single-wire LED strips driven in parallel. Each
// transaction on the slave stream carries one pixel position (red, green and blue for
// every strip); each channel is gamma corrected on entry and the pixel then leaves as
// 24 slot transactions on the master stream, colour by colour in the configured wire
// order, msb first, with one compare value per strip. The slot counter walks the
// lanes' shift registers and moves on only while the master stream is not stalled;
// the next pixel is accepted in the same cycle that the final slot of the previous
// one enters the output register, so a new pixel is taken before the last slot of
// the old one has left. A blank command gives 24 zero slots for the reset gap.
// Configuration writes are expected only while no pixel is in flight.
module led_strip_pulse_encoder #(
  parameter int STRIP_COUNT = 3
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // red_strip0, green_strip0, blue_strip0, red_strip1, green_strip1, blue_strip1,
  // red_strip2, green_strip2, blue_strip2
  input  logic [71:0] s_axis_tdata,
  // cmd
  input  logic        s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // width_strip0, width_strip1, width_strip2, slot_colour, slot_bit, 3 zero bits
  output logic [31:0] m_axis_tdata,
  // last_slot
  output logic        m_axis_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_data
);

  lsp_pkg::byte_t                 one_bit_high_width;
  lsp_pkg::byte_t                 zero_bit_high_width;
  lsp_pkg::order_t                colour_order;
  lsp_pkg::lane_ctrl_t            lane_ctrl;
  logic [lsp_pkg::MAX_STRIPS-1:0] lane_bits;
  lsp_pkg::byte_t                 width [lsp_pkg::MAX_STRIPS];
  lsp_pkg::colour_t               slot_colour;
  lsp_pkg::bit_idx_t              slot_bit;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      one_bit_high_width  <= '0;
      zero_bit_high_width <= '0;
      colour_order        <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        lsp_pkg::REG_ONE_WIDTH:    one_bit_high_width  <= cfg_data;
        lsp_pkg::REG_ZERO_WIDTH:   zero_bit_high_width <= cfg_data;
        lsp_pkg::REG_COLOUR_ORDER: colour_order        <= cfg_data[2:0];
        default: ;
      endcase
    end
  end

  for (genvar s = 0; s < lsp_pkg::MAX_STRIPS; s++) begin : g_lane
    if (s < STRIP_COUNT) begin : g_used
      lsp_lane u_lane (
        .clk          (clk),
        .ctrl         (lane_ctrl),
        .colour_order (colour_order),
        .red          (s_axis_tdata[s*24 +: 8]),
        .green        (s_axis_tdata[s*24 + 8 +: 8]),
        .blue         (s_axis_tdata[s*24 + 16 +: 8]),
        .bit_out      (lane_bits[s])
      );
    end else begin : g_unused
      assign lane_bits[s] = 1'b0;
    end
  end

  lsp_merge #(
    .STRIP_COUNT (STRIP_COUNT)
  ) u_merge (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_axis_tvalid),
    .in_ready   (s_axis_tready),
    .in_blank   (s_axis_tuser),
    .one_width  (one_bit_high_width),
    .zero_width (zero_bit_high_width),
    .lane_bits  (lane_bits),
    .lane_ctrl  (lane_ctrl),
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready),
    .out_width  (width),
    .out_colour (slot_colour),
    .out_bit    (slot_bit),
    .out_last   (m_axis_tlast)
  );

  assign m_axis_tdata = {3'b000, slot_bit, slot_colour, width[2], width[1], width[0]};

endmodule
